// ----- hw/rtl/psxy_pkg.sv -----
// ----------------------------------------------------------------------------
// psxy_pkg: shared types for the point sorter
// Coordinate width, the point and item types and the cell control group.
// ----------------------------------------------------------------------------
package psxy_pkg;

    localparam int COORD_BITS = 16;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        logic   final_point;
    } in_item_t;

    typedef struct packed {
        coord_t sorted_x;
        coord_t sorted_y;
        logic   last_out;
        logic   overflow;
    } out_item_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/psxy_cell.sv -----
// ----------------------------------------------------------------------------
// psxy_cell: one slot of the insertion chain
// Holds one point, compares it with the broadcast point and either keeps it,
// takes its left neighbour's point or the new point, or shifts left to drain.
// ----------------------------------------------------------------------------
module psxy_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  psxy_pkg::cell_ctrl_t ctrl,
    input  psxy_pkg::point_t    new_point,
    input  logic                left_valid,
    input  logic                left_place,
    input  psxy_pkg::point_t    left_point,
    input  logic                right_valid,
    input  psxy_pkg::point_t    right_point,
    output logic                valid,
    output logic                place,
    output psxy_pkg::point_t    point
);
    import psxy_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    point_t point_reg;
    point_t point_next;
    logic   greater;

    // Lexicographic compare: stored point lies after the new one.
    assign greater = (point_reg.x > new_point.x) ||
                     ((point_reg.x == new_point.x) && (point_reg.y > new_point.y));

    // This slot changes on insertion when it is empty or its point moves right.
    assign place = !valid_reg || greater;

    always_comb begin
        valid_next = valid_reg;
        point_next = point_reg;
        if (ctrl.shift) begin
            valid_next = right_valid;
            point_next = right_point;
        end else if (ctrl.insert && place) begin
            valid_next = valid_reg || left_valid;
            point_next = left_place ? left_point : new_point;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        point_reg <= point_next;
    end

    assign valid = valid_reg;
    assign point = point_reg;

endmodule

// ----- hw/rtl/point_sort_by_x_then_y.sv -----
// ----------------------------------------------------------------------------
// point_sort_by_x_then_y: lexicographic insertion sorter for point batches
// A chain of MAX_POINTS cells keeps the batch ordered by x, then y.
// ----------------------------------------------------------------------------
// Points of a batch are taken one per cycle: the arriving point is broadcast
// along the cell chain and every cell decides in the same cycle whether to
// keep, shift right or capture it. After the item marked final the input
// stalls while the chain drains towards cell zero, one result per cycle
// while the receiver is ready. Points that arrive with the chain full are
// dropped and every result of that batch carries the overflow flag.
module point_sort_by_x_then_y #(
    parameter int MAX_POINTS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  psxy_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output psxy_pkg::out_item_t  m_item
);
    import psxy_pkg::*;

    logic       drain_reg;
    logic       drain_next;
    logic       dropped_reg;
    logic       dropped_next;
    logic       in_acc;
    logic       out_acc;
    logic       full;
    cell_ctrl_t ctrl;
    point_t     new_point;

    logic   [MAX_POINTS-1:0] valid_vec;
    logic   [MAX_POINTS-1:0] place_vec;
    point_t                  point_vec [MAX_POINTS];

    assign s_ready   = !drain_reg;
    assign in_acc    = s_valid && s_ready;
    assign m_valid   = drain_reg && valid_vec[0];
    assign out_acc   = m_valid && m_ready;
    assign full      = valid_vec[MAX_POINTS-1];
    assign new_point = '{x: s_item.point_x, y: s_item.point_y};

    assign ctrl.insert = in_acc && !full;
    assign ctrl.shift  = out_acc;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_POINTS; gi++) begin : g_cell
            logic   lv;
            logic   lp;
            point_t lpt;
            logic   rv;
            point_t rpt;

            if (gi == 0) begin : g_head
                assign lv  = 1'b1;
                assign lp  = 1'b0;
                assign lpt = new_point;
            end else begin : g_body
                assign lv  = valid_vec[gi-1];
                assign lp  = place_vec[gi-1];
                assign lpt = point_vec[gi-1];
            end

            if (gi == MAX_POINTS-1) begin : g_tail
                assign rv  = 1'b0;
                assign rpt = point_vec[gi];
            end else begin : g_inner
                assign rv  = valid_vec[gi+1];
                assign rpt = point_vec[gi+1];
            end

            psxy_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .new_point   (new_point),
                .left_valid  (lv),
                .left_place  (lp),
                .left_point  (lpt),
                .right_valid (rv),
                .right_point (rpt),
                .valid       (valid_vec[gi]),
                .place       (place_vec[gi]),
                .point       (point_vec[gi])
            );
        end
    endgenerate

    always_comb begin
        drain_next   = drain_reg;
        dropped_next = dropped_reg;
        if (in_acc) begin
            if (full) begin
                dropped_next = 1'b1;
            end
            if (s_item.final_point) begin
                drain_next = 1'b1;
            end
        end
        if (out_acc && m_item.last_out) begin
            drain_next   = 1'b0;
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drain_reg   <= 1'b0;
            dropped_reg <= 1'b0;
        end else begin
            drain_reg   <= drain_next;
            dropped_reg <= dropped_next;
        end
    end

    assign m_item.sorted_x = point_vec[0].x;
    assign m_item.sorted_y = point_vec[0].y;
    assign m_item.last_out = !valid_vec[1];
    assign m_item.overflow = dropped_reg;

    // The input stays closed for the whole drain of a batch.
    a_no_input_while_draining: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input open while results are pending");

    // An insertion into a chain with room adds exactly one stored point.
    a_insert_grows_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.insert |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
        else $error("insertion did not add one point");

    // Taking the last result leaves the chain empty and the batch closed.
    a_batch_ends_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc && m_item.last_out |=> !drain_reg && valid_vec == '0 && !dropped_reg)
        else $error("chain not empty after last result");

    // Stored points occupy a prefix of the chain; checked here at its first two cells.
    a_valid_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_vec[1] |-> valid_vec[0])
        else $error("gap at the head of the chain");

endmodule

// ----- dv/point_sort_by_x_then_y_tb.sv -----
// ----------------------------------------------------------------------------
// point_sort_by_x_then_y_tb: self-checking bench for the point sorter
// Feeds batches of signed points, predicts each sorted batch in the bench and
// compares every result item field by field, under random idling on both
// channels, a long receiver hold-off and batches that overflow the store.
// ----------------------------------------------------------------------------
module point_sort_by_x_then_y_tb;
    import psxy_pkg::*;

    localparam int          MAX_PTS      = 64;
    localparam int unsigned ITEM_TARGET  = 500;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 2 * MAX_PTS + 16;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    typedef enum int unsigned {MIX_NARROW, MIX_EXTREME, MIX_FULL} coord_mix_t;

    // One row of the directed part. Where fixed_want is set, the row is a
    // batch of one point and its result is written out in full.
    typedef struct packed {
        in_item_t  pt;
        logic      fixed_want;
        out_item_t want;
    } stim_row_t;

    localparam int DIR_COUNT = 16;
    localparam stim_row_t DIR_ROWS [DIR_COUNT] = '{
        '{'{16'sh7FFF, 16'sh8000, 1'b1}, 1'b1, '{16'sh7FFF, 16'sh8000, 1'b1, 1'b0}},
        '{'{16'sh8000, 16'sh7FFF, 1'b1}, 1'b1, '{16'sh8000, 16'sh7FFF, 1'b1, 1'b0}},
        '{'{16'sh0000, 16'sh0000, 1'b1}, 1'b1, '{16'sh0000, 16'sh0000, 1'b1, 1'b0}},
        '{'{16'shFFFF, 16'shFFFF, 1'b1}, 1'b1, '{16'shFFFF, 16'shFFFF, 1'b1, 1'b0}},
        // Falling x, equal x with differing y, a repeated point and both extremes.
        '{'{16'sh7FFF, 16'sh7FFF, 1'b0}, 1'b0, '0},
        '{'{16'sh0005, 16'sh0003, 1'b0}, 1'b0, '0},
        '{'{16'sh0005, 16'shFFFD, 1'b0}, 1'b0, '0},
        '{'{16'sh0005, 16'sh0003, 1'b0}, 1'b0, '0},
        '{'{16'sh8000, 16'sh8000, 1'b0}, 1'b0, '0},
        '{'{16'shFFFF, 16'sh7FFF, 1'b0}, 1'b0, '0},
        '{'{16'sh0000, 16'shFFFF, 1'b1}, 1'b0, '0},
        // Already in order, all on one x.
        '{'{16'shFFFE, 16'shFFFB, 1'b0}, 1'b0, '0},
        '{'{16'shFFFE, 16'sh0000, 1'b0}, 1'b0, '0},
        '{'{16'shFFFE, 16'sh7FFF, 1'b1}, 1'b0, '0},
        // Two identical points.
        '{'{16'sh1234, 16'shA5A5, 1'b0}, 1'b0, '0},
        '{'{16'sh1234, 16'shA5A5, 1'b1}, 1'b0, '0}
    };

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    point_sort_by_x_then_y #(
        .MAX_POINTS(MAX_PTS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Bench copy of the ordered store.
    point_t      sort_store [MAX_PTS];
    int          held_points;
    logic        points_dropped;
    out_item_t   batch_sorted[$];
    out_item_t   sorted_due[$];

    int unsigned fault_count;
    int unsigned items_sent;
    int unsigned batches_sent;
    int unsigned results_checked;
    int unsigned overflow_seen;
    int unsigned hold_offs;
    int unsigned cycle_count;
    logic        hold_off_req;
    logic        tx_steady;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Inserts one point into the bench store, or marks it dropped when the store is
    // full; on the final point the whole batch is put into batch_sorted and the store is emptied.
    function automatic void place_point(input in_item_t item);
        point_t    p;
        int        slot;
        out_item_t r;
        p.x = item.point_x;
        p.y = item.point_y;
        if (held_points < MAX_PTS) begin
            slot = held_points;
            while (slot > 0 && (sort_store[slot-1].x > p.x ||
                   (sort_store[slot-1].x == p.x && sort_store[slot-1].y > p.y))) begin
                sort_store[slot] = sort_store[slot-1];
                slot--;
            end
            sort_store[slot] = p;
            held_points++;
        end else begin
            points_dropped = 1'b1;
        end
        if (item.final_point) begin
            for (int k = 0; k < held_points; k++) begin
                r.sorted_x = sort_store[k].x;
                r.sorted_y = sort_store[k].y;
                r.last_out = (k == held_points - 1);
                r.overflow = points_dropped;
                batch_sorted.push_back(r);
            end
            held_points    = 0;
            points_dropped = 1'b0;
        end
    endfunction

    function automatic coord_t draw_coord(input coord_mix_t mix);
        case (mix)
            MIX_NARROW: begin
                return coord_t'(int'($urandom_range(0, 6)) - 3);
            end
            MIX_EXTREME: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
            default: begin
                return coord_t'($urandom);
            end
        endcase
    endfunction

    // Offers one item and returns at the edge that takes it. Valid is only
    // lowered when a gap is drawn, so back-to-back items keep it high.
    task automatic send_item(input in_item_t item, input logic fixed_want,
                             input out_item_t want);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= item;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        batch_sorted.delete();
        place_point(item);
        if (item.final_point) begin
            batches_sent++;
            if (fixed_want) begin
                sorted_due.push_back(want);
            end else begin
                foreach (batch_sorted[k]) sorted_due.push_back(batch_sorted[k]);
            end
        end
    endtask

    task automatic send_batch(input int unsigned size);
        coord_mix_t mix_x;
        coord_mix_t mix_y;
        in_item_t   it;
        mix_x = coord_mix_t'($urandom_range(0, 2));
        mix_y = coord_mix_t'($urandom_range(0, 2));
        tx_steady = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < size; k++) begin
            it.point_x     = draw_coord(mix_x);
            it.point_y     = draw_coord(mix_y);
            it.final_point = (k == size - 1);
            send_item(it, 1'b0, '0);
        end
    endtask

    task automatic wait_sorted_due_empty();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sorted_due.size() != 0) @(posedge aclk);
    endtask

    // Receiver: a drawn stall before each result, with steady stretches and
    // one long hold-off when the sender asks for it.
    initial begin
        int unsigned stall;
        logic        rx_steady;
        out_item_t   want;
        m_ready   = 1'b0;
        rx_steady = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 19) == 0) rx_steady = ~rx_steady;
            if (hold_off_req) begin
                stall        = HOLD_CYCLES;
                hold_off_req = 1'b0;
                hold_offs++;
            end else begin
                stall = rx_steady ? 0 : $urandom_range(0, 16);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (sorted_due.size() == 0) begin
                $error("result item with nothing expected: x=%0d y=%0d last=%0b ovf=%0b",
                       m_item.sorted_x, m_item.sorted_y, m_item.last_out, m_item.overflow);
                fault_count++;
            end else begin
                want = sorted_due.pop_front();
                results_checked++;
                if (want.overflow) overflow_seen++;
                if (m_item.sorted_x !== want.sorted_x) begin
                    $error("sorted_x: expected %0d, got %0d", want.sorted_x, m_item.sorted_x);
                    fault_count++;
                end
                if (m_item.sorted_y !== want.sorted_y) begin
                    $error("sorted_y: expected %0d, got %0d", want.sorted_y, m_item.sorted_y);
                    fault_count++;
                end
                if (m_item.last_out !== want.last_out) begin
                    $error("last_out: expected %0b, got %0b", want.last_out, m_item.last_out);
                    fault_count++;
                end
                if (m_item.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b", want.overflow, m_item.overflow);
                    fault_count++;
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("point_sort_by_x_then_y_tb: errors");
        $finish;
    end

    initial begin
        int unsigned batch_idx;
        int unsigned size;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_item         = '0;
        held_points    = 0;
        points_dropped = 1'b0;
        fault_count    = 0;
        items_sent     = 0;
        batches_sent   = 0;
        results_checked = 0;
        overflow_seen  = 0;
        hold_offs      = 0;
        hold_off_req   = 1'b0;
        tx_steady      = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIR_ROWS[r]) send_item(DIR_ROWS[r].pt, DIR_ROWS[r].fixed_want, DIR_ROWS[r].want);

        batch_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            case (batch_idx)
                3:  size = MAX_PTS;                              // exactly full
                7:  size = MAX_PTS + 1;                          // final point dropped
                11: size = MAX_PTS + $urandom_range(2, 10);      // several dropped
                default: begin
                    size = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40)
                                                       : $urandom_range(1, 8);
                end
            endcase
            // The receiver stops for a long while here, so the sorter drains
            // into a blocked output and the next batch waits at the input.
            if (batch_idx == 15) hold_off_req = 1'b1;
            send_batch(size);
            if (batch_idx == 20) wait_sorted_due_empty();
            batch_idx++;
        end

        wait_sorted_due_empty();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d items in %0d batches, %0d result items checked (%0d with overflow)",
                 items_sent, batches_sent, results_checked, overflow_seen);
        $display("%0d long receiver hold-off(s), %0d cycles", hold_offs, cycle_count);
        if (fault_count == 0 && sorted_due.size() == 0) begin
            $display("point_sort_by_x_then_y_tb: clean");
        end else begin
            $display("point_sort_by_x_then_y_tb: errors");
        end
        $finish;
    end

endmodule

// ----- point_sort_by_x_then_y.f -----
hw/rtl/psxy_pkg.sv
hw/rtl/psxy_cell.sv
hw/rtl/point_sort_by_x_then_y.sv
dv/point_sort_by_x_then_y_tb.sv
